// ===== hw/rtl/ppa_pkg.sv =====
package ppa_pkg;

	// Grid geometry limits.
	localparam int MAX_WIDTH = 64;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 12;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RABBIT_MAX_AGE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FOX_MAX_AGE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FOX_CROWD_LIMIT = 3'd4;

	// Register reset values.
	localparam logic [6:0]       RST_GRID_WIDTH      = 7'd40;
	localparam logic [ROW_W-1:0] RST_GRID_HEIGHT     = 12'd40;
	localparam logic [2:0]       RST_RABBIT_MAX_AGE  = 3'd3;
	localparam logic [2:0]       RST_FOX_MAX_AGE     = 3'd6;
	localparam logic [3:0]       RST_FOX_CROWD_LIMIT = 4'd5;

	// Spawn thresholds for an empty cell and the age ceiling.
	localparam logic [3:0] SPAWN_FOX_MIN    = 4'd1;
	localparam logic [3:0] SPAWN_RABBIT_MIN = 4'd1;
	localparam logic [3:0] SPAWN_GRASS_MIN  = 4'd0;
	localparam logic [2:0] AGE_TOP          = 3'd7;

	typedef enum logic [1:0] {
		K_EMPTY  = 2'd0,
		K_GRASS  = 2'd1,
		K_RABBIT = 2'd2,
		K_FOX    = 2'd3
	} kind_t;

	// One grid cell as stored: age above kind.
	typedef struct packed {
		logic [2:0] age;
		kind_t      kind;
	} cell_t;

	// One line buffer entry: the cell two rows up and the cell one row up.
	typedef struct packed {
		cell_t up;
		cell_t mid;
	} line_entry_t;

endpackage

// ===== hw/rtl/ppa_line_buf.sv =====
module ppa_line_buf (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [ppa_pkg::COL_W-1:0]  rd_addr,
	output ppa_pkg::line_entry_t       rd_data,
	input  logic                       wr_en,
	input  logic [ppa_pkg::COL_W-1:0]  wr_addr,
	input  ppa_pkg::line_entry_t       wr_data
);
	import ppa_pkg::*;

	line_entry_t mem [MAX_WIDTH];

	// Both rows of the column live in one entry; the read data is registered.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/ppa_evolve.sv =====
module ppa_evolve (
	input  ppa_pkg::cell_t [8:0]  win,
	input  logic [2:0]            rabbit_max_age,
	input  logic [2:0]            fox_max_age,
	input  logic [3:0]            fox_crowd_limit,
	output ppa_pkg::kind_t        kind,
	output logic [2:0]            age
);
	import ppa_pkg::*;

	// Count of one kind among three cells.
	function automatic logic [1:0] count3(cell_t a, cell_t b, cell_t c, kind_t k);
		logic [1:0] n;
		n = {1'b0, a.kind == k} + {1'b0, b.kind == k} + {1'b0, c.kind == k};
		return n;
	endfunction

	function automatic logic [3:0] count9(cell_t [8:0] w, kind_t k);
		logic [1:0] r0, r1, r2;
		r0 = count3(w[0], w[1], w[2], k);
		r1 = count3(w[3], w[4], w[5], k);
		r2 = count3(w[6], w[7], w[8], k);
		return {2'b00, r0} + {2'b00, r1} + {2'b00, r2};
	endfunction

	logic [3:0] n_grass, n_rabbit, n_fox;
	logic [2:0] aged;
	cell_t      ctr;

	assign ctr      = win[4];
	assign n_grass  = count9(win, K_GRASS);
	assign n_rabbit = count9(win, K_RABBIT);
	assign n_fox    = count9(win, K_FOX);
	assign aged     = (ctr.age >= AGE_TOP) ? AGE_TOP : ctr.age + 3'd1;

	// Survival, death and spawn rules for the center cell.
	always_comb begin
		kind = K_EMPTY;
		age  = 3'd0;
		case (ctr.kind)
			K_GRASS: begin
				if (n_grass > n_rabbit) kind = K_GRASS;
			end
			K_RABBIT: begin
				if (n_fox < n_rabbit && ctr.age <= rabbit_max_age) begin
					kind = K_RABBIT;
					age  = aged;
				end
			end
			K_FOX: begin
				if (n_fox <= fox_crowd_limit && ctr.age <= fox_max_age) begin
					kind = K_FOX;
					age  = aged;
				end
			end
			default: begin
				if (n_fox > SPAWN_FOX_MIN) kind = K_FOX;
				else if (n_rabbit > SPAWN_RABBIT_MIN) kind = K_RABBIT;
				else if (n_grass > SPAWN_GRASS_MIN) kind = K_GRASS;
			end
		endcase
	end

endmodule

// ===== hw/rtl/predator_prey_automaton_step_top.sv =====
// Channel   Direction  Handshake                Payload
// input     in         in_valid / in_ready      cell_kind, cell_age
// output    out        out_valid / out_ready    out_row, out_col, new_kind, new_age, frame_done
// config    in         cfg_we                   cfg_index, cfg_data
//
// One cell is taken per clock while the output is not stalled. Each result passes
// through three register stages (line buffer read, window shift, rule evaluation).
// Reset clears the counters, the stage valid bits and the registers to their defaults;
// the line buffers and window are not cleared, as unwritten entries never reach a result.
// A stalled output holds its result while the stages behind it keep filling until full.
module predator_prey_automaton_step_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    cell_kind,
	input  logic [2:0]                    cell_age,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ppa_pkg::ROW_W-1:0]     out_row,
	output logic [ppa_pkg::COL_W-1:0]     out_col,
	output logic [1:0]                    new_kind,
	output logic [2:0]                    new_age,
	output logic                          frame_done,
	input  logic                          cfg_we,
	input  logic [ppa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ppa_pkg::CFG_DAT_W-1:0] cfg_data
);
	import ppa_pkg::*;

	typedef struct packed {
		cell_t            din;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row_m1;
		logic [COL_W-1:0] col_m1;
		logic             inrange;
		logic             emit;
		logic             frame;
	} s1_t;

	// Configuration registers.
	logic [6:0]       grid_width_q;
	logic [ROW_W-1:0] grid_height_q;
	logic [2:0]       rabbit_max_age_q;
	logic [2:0]       fox_max_age_q;
	logic [3:0]       fox_crowd_limit_q;

	logic [6:0]       w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W:0]   col_inc;
	logic [ROW_W:0]   row_inc;

	logic             in_xfer;
	logic             s1_v, s1_adv, s2_v, s2_adv, s2_free, out_free;
	s1_t              s1;
	line_entry_t      rd_s1;
	logic             lb_wr_en;
	line_entry_t      lb_wr_data;

	cell_t [8:0]      win_q;
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;
	logic             emit_s2, frame_s2;

	kind_t            ev_kind;
	logic [2:0]       ev_age;
	logic             out_valid_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q      <= RST_GRID_WIDTH;
			grid_height_q     <= RST_GRID_HEIGHT;
			rabbit_max_age_q  <= RST_RABBIT_MAX_AGE;
			fox_max_age_q     <= RST_FOX_MAX_AGE;
			fox_crowd_limit_q <= RST_FOX_CROWD_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:      grid_width_q      <= cfg_data[6:0];
				CFG_GRID_HEIGHT:     grid_height_q     <= cfg_data[ROW_W-1:0];
				CFG_RABBIT_MAX_AGE:  rabbit_max_age_q  <= cfg_data[2:0];
				CFG_FOX_MAX_AGE:     fox_max_age_q     <= cfg_data[2:0];
				CFG_FOX_CROWD_LIMIT: fox_crowd_limit_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Effective grid size, clamped to the supported range.
	always_comb begin
		if (grid_width_q < 7'd3) w_eff = 7'd3;
		else if (grid_width_q > 7'(MAX_WIDTH)) w_eff = 7'(MAX_WIDTH);
		else w_eff = grid_width_q;
		h_eff = (grid_height_q < 12'd3) ? 12'd3 : grid_height_q;
	end

	// Handshake chain from the output back to the input.
	assign out_free = !out_valid_q || out_ready;
	assign s2_adv   = s2_v && (!emit_s2 || out_free);
	assign s2_free  = !s2_v || s2_adv;
	assign s1_adv   = s1_v && s2_free;
	assign in_ready = !s1_v || s1_adv;
	assign in_xfer  = in_valid && in_ready;

	assign col_inc = {1'b0, col_q} + 1'b1;
	assign row_inc = {1'b0, row_q} + 1'b1;

	// Raster position counters advance on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (col_inc >= {1'b0, w_eff}) begin
				col_q <= '0;
				row_q <= (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	// Stage 1: the incoming cell and its position flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (in_ready) begin
			s1_v <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			s1.din     <= '{age: cell_age, kind: kind_t'(cell_kind)};
			s1.col     <= col_q;
			s1.row_m1  <= row_q - 12'd1;
			s1.col_m1  <= col_q - 6'd1;
			s1.inrange <= ({1'b0, col_q} < w_eff) && (row_q < h_eff);
			s1.emit    <= ({1'b0, col_q} < w_eff) && (row_q < h_eff)
				&& (row_q >= 12'd2) && (col_q >= 6'd2);
			s1.frame   <= (row_q == h_eff - 12'd1) && ({1'b0, col_q} == w_eff - 7'd1);
		end
	end

	// Line buffers: read on transfer, write back shifted rows as the cell moves on.
	assign lb_wr_en   = s1_adv && s1.inrange;
	assign lb_wr_data = '{up: rd_s1.mid, mid: s1.din};

	ppa_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (rd_s1),
		.wr_en   (lb_wr_en),
		.wr_addr (s1.col),
		.wr_data (lb_wr_data)
	);

	// Stage 2: the 3x3 window shifts left and takes the new column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s2_free) begin
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			row_s2   <= s1.row_m1;
			col_s2   <= s1.col_m1;
			emit_s2  <= s1.emit;
			frame_s2 <= s1.frame;
			if (s1.inrange) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= rd_s1.up;
				win_q[3] <= win_q[4];
				win_q[4] <= win_q[5];
				win_q[5] <= rd_s1.mid;
				win_q[6] <= win_q[7];
				win_q[7] <= win_q[8];
				win_q[8] <= s1.din;
			end
		end
	end

	ppa_evolve u_evolve (
		.win             (win_q),
		.rabbit_max_age  (rabbit_max_age_q),
		.fox_max_age     (fox_max_age_q),
		.fox_crowd_limit (fox_crowd_limit_q),
		.kind            (ev_kind),
		.age             (ev_age)
	);

	// Output register: only interior cells are handed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s2_v && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s2_v && emit_s2) begin
			out_row    <= row_s2;
			out_col    <= col_s2;
			new_kind   <= ev_kind;
			new_age    <= ev_age;
			frame_done <= frame_s2;
		end
	end

	assign out_valid = out_valid_q;

	// The last interior cell sits one column left of the right border.
	a_frame_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_done |-> ({1'b0, out_col} == w_eff - 7'd2))
		else $error("frame_done on a column other than the last interior one");

	// A column is never written back in the cycle it is read for a new cell.
	a_lb_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		lb_wr_en && in_xfer |-> (s1.col != col_q))
		else $error("line buffer read and write collide on one column");

	// Reported cells are never on the top or left border.
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_row != 12'd0) && (out_col != 6'd0))
		else $error("border cell reported");

endmodule

// ===== sim/ppa_step_checker.sv =====
module ppa_step_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [1:0]                    cell_kind,
	input  logic [2:0]                    cell_age,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [ppa_pkg::ROW_W-1:0]     out_row,
	input  logic [ppa_pkg::COL_W-1:0]     out_col,
	input  logic [1:0]                    new_kind,
	input  logic [2:0]                    new_age,
	input  logic                          frame_done,
	input  logic                          cfg_we,
	input  logic [ppa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ppa_pkg::CFG_DAT_W-1:0] cfg_data,
	output int                            fail_count,
	output int                            open_updates,
	output int                            updates_checked
);
	import ppa_pkg::*;

	// One reported interior cell of the next generation.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		kind_t            kind;
		logic [2:0]       age;
		logic             frame_end;
	} cell_update_t;

	cell_update_t expected_updates[$];

	// Shadow copy of the registers and of the grid stream state.
	logic [6:0]       grid_width;
	logic [ROW_W-1:0] grid_height;
	logic [2:0]       rabbit_age_lim;
	logic [2:0]       fox_age_lim;
	logic [3:0]       fox_crowd_lim;
	cell_t            upper_row [MAX_WIDTH];
	cell_t            middle_row [MAX_WIDTH];
	cell_t            window [9];
	int unsigned      row_at;
	int unsigned      col_at;

	// Take one cell of the old grid and queue the update it produces, if any.
	task automatic advance_grid(input cell_t cur);
		int unsigned  w;
		int unsigned  h;
		int unsigned  cnt [4];
		cell_t        col3 [3];
		cell_update_t upd;
		kind_t        ck;
		logic [2:0]   ca;
		w = (grid_width < 3) ? 3 : grid_width;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		h = (grid_height < 3) ? 3 : grid_height;
		if (col_at < w && row_at < h) begin
			col3[0] = upper_row[col_at];
			col3[1] = middle_row[col_at];
			col3[2] = cur;
			for (int i = 0; i < 3; i++) begin
				window[i*3]     = window[i*3+1];
				window[i*3+1]   = window[i*3+2];
				window[i*3+2]   = col3[i];
			end
			upper_row[col_at]  = middle_row[col_at];
			middle_row[col_at] = cur;
			if (row_at >= 2 && col_at >= 2) begin
				for (int i = 0; i < 4; i++)
					cnt[i] = 0;
				for (int i = 0; i < 9; i++)
					cnt[window[i].kind] = cnt[window[i].kind] + 1;
				ck = window[4].kind;
				ca = window[4].age;
				upd.kind = K_EMPTY;
				upd.age  = 3'd0;
				case (ck)
					K_GRASS: begin
						if (cnt[K_GRASS] > cnt[K_RABBIT])
							upd.kind = K_GRASS;
					end
					K_RABBIT: begin
						if (cnt[K_FOX] < cnt[K_RABBIT] && ca <= rabbit_age_lim) begin
							upd.kind = K_RABBIT;
							upd.age  = (ca == AGE_TOP) ? AGE_TOP : ca + 3'd1;
						end
					end
					K_FOX: begin
						if (cnt[K_FOX] <= fox_crowd_lim && ca <= fox_age_lim) begin
							upd.kind = K_FOX;
							upd.age  = (ca == AGE_TOP) ? AGE_TOP : ca + 3'd1;
						end
					end
					default: begin
						// Empty cell: foxes take priority over rabbits over grass.
						if (cnt[K_FOX] > SPAWN_FOX_MIN)
							upd.kind = K_FOX;
						else if (cnt[K_RABBIT] > SPAWN_RABBIT_MIN)
							upd.kind = K_RABBIT;
						else if (cnt[K_GRASS] > SPAWN_GRASS_MIN)
							upd.kind = K_GRASS;
					end
				endcase
				upd.row       = ROW_W'(row_at - 1);
				upd.col       = COL_W'(col_at - 1);
				upd.frame_end = (row_at == h - 1 && col_at == w - 1);
				expected_updates.push_back(upd);
			end
		end
		// Counters past a reduced size wrap without producing anything.
		col_at++;
		if (col_at >= w) begin
			col_at = 0;
			row_at++;
			if (row_at >= h)
				row_at = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		cell_t        incoming;
		cell_update_t want;
		if (!arst_n) begin
			grid_width     = RST_GRID_WIDTH;
			grid_height    = RST_GRID_HEIGHT;
			rabbit_age_lim = RST_RABBIT_MAX_AGE;
			fox_age_lim    = RST_FOX_MAX_AGE;
			fox_crowd_lim  = RST_FOX_CROWD_LIMIT;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_row[i]  = '0;
				middle_row[i] = '0;
			end
			for (int i = 0; i < 9; i++)
				window[i] = '0;
			row_at = 0;
			col_at = 0;
			expected_updates.delete();
			fail_count      = 0;
			updates_checked = 0;
		end else begin
			// Register writes take effect at once.
			if (cfg_we) begin
				case (cfg_index)
					CFG_GRID_WIDTH:      grid_width     = cfg_data[6:0];
					CFG_GRID_HEIGHT:     grid_height    = cfg_data[ROW_W-1:0];
					CFG_RABBIT_MAX_AGE:  rabbit_age_lim = cfg_data[2:0];
					CFG_FOX_MAX_AGE:     fox_age_lim    = cfg_data[2:0];
					CFG_FOX_CROWD_LIMIT: fox_crowd_lim  = cfg_data[3:0];
					default: ;
				endcase
			end

			// Input transfer: advance the predicted grid.
			if (in_valid && in_ready) begin
				incoming.kind = kind_t'(cell_kind);
				incoming.age  = cell_age;
				advance_grid(incoming);
			end

			// Output transfer: compare with the oldest predicted update.
			if (out_valid && out_ready) begin
				if (expected_updates.size() == 0) begin
					$error("cell update at row %0d col %0d with none predicted",
						out_row, out_col);
					fail_count++;
				end else begin
					want = expected_updates.pop_front();
					updates_checked++;
					if (out_row !== want.row) begin
						$error("out_row: expected %0d, got %0d", want.row, out_row);
						fail_count++;
					end
					if (out_col !== want.col) begin
						$error("out_col: expected %0d, got %0d", want.col, out_col);
						fail_count++;
					end
					if (new_kind !== want.kind) begin
						$error("new_kind: expected %0d, got %0d", want.kind, new_kind);
						fail_count++;
					end
					if (new_age !== want.age) begin
						$error("new_age: expected %0d, got %0d", want.age, new_age);
						fail_count++;
					end
					if (frame_done !== want.frame_end) begin
						$error("frame_done: expected %0d, got %0d", want.frame_end,
							frame_done);
						fail_count++;
					end
				end
			end
		end
		open_updates = expected_updates.size();
	end

endmodule

// ===== sim/tb_predator_prey_automaton_step_top.sv =====
module tb_predator_prey_automaton_step_top;
	import ppa_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_CELLS = 700;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic [1:0]           cell_kind = 2'd0;
	logic [2:0]           cell_age  = 3'd0;
	logic                 out_ready = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_GRID_WIDTH;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;

	logic                 in_ready;
	logic                 out_valid;
	logic [ROW_W-1:0]     out_row;
	logic [COL_W-1:0]     out_col;
	logic [1:0]           new_kind;
	logic [2:0]           new_age;
	logic                 frame_done;

	int fail_count;
	int open_updates;
	int updates_checked;
	int cells_sent    = 0;
	int settings_used = 0;
	int burst_left    = 0;
	int idle_cycles   = 0;
	int stall_mode    = 0;
	int stall_left    = 0;
	int stall_tick    = 0;

	predator_prey_automaton_step_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cell_kind  (cell_kind),
		.cell_age   (cell_age),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_row    (out_row),
		.out_col    (out_col),
		.new_kind   (new_kind),
		.new_age    (new_age),
		.frame_done (frame_done),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	ppa_step_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cell_kind       (cell_kind),
		.cell_age        (cell_age),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_row         (out_row),
		.out_col         (out_col),
		.new_kind        (new_kind),
		.new_age         (new_age),
		.frame_done      (frame_done),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.open_updates    (open_updates),
		.updates_checked (updates_checked)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Receiver: switches between always ready, light stalls, heavy stalls and a fixed
	// pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(16, 200);
			end else begin
				stall_left--;
			end
			stall_tick++;
			case (stall_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 3) != 0);
				2:       out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (stall_tick % 8 < 5);
			endcase
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$error("no transfer for %0d cycles", idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// A register write; the caller lowers the write enable after the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic program_grid(input logic [6:0] w, input logic [ROW_W-1:0] h,
			input logic [2:0] rabbit_age, input logic [2:0] fox_age,
			input logic [3:0] crowd);
		write_reg(CFG_GRID_WIDTH, CFG_DAT_W'(w));
		write_reg(CFG_GRID_HEIGHT, CFG_DAT_W'(h));
		write_reg(CFG_RABBIT_MAX_AGE, CFG_DAT_W'(rabbit_age));
		write_reg(CFG_FOX_MAX_AGE, CFG_DAT_W'(fox_age));
		write_reg(CFG_FOX_CROWD_LIMIT, CFG_DAT_W'(crowd));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Offer one cell and hold it until its transfer; bursts are broken by random gaps.
	task automatic send_cell(input cell_t cur);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			if ($urandom_range(0, 2) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		cell_kind <= cur.kind;
		cell_age  <= cur.age;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		cells_sent++;
	endtask

	// Random cells under a population mix: uniform, fox-heavy, rabbit-heavy or sparse.
	task automatic send_random(input int count, input int mix);
		cell_t cur;
		int    p;
		for (int i = 0; i < count; i++) begin
			p = $urandom_range(0, 99);
			case (mix)
				1:       cur.kind = (p < 50) ? K_FOX : (p < 70) ? K_RABBIT :
						(p < 85) ? K_GRASS : K_EMPTY;
				2:       cur.kind = (p < 50) ? K_RABBIT : (p < 65) ? K_FOX :
						(p < 85) ? K_GRASS : K_EMPTY;
				3:       cur.kind = (p < 60) ? K_EMPTY : (p < 80) ? K_GRASS :
						(p < 90) ? K_RABBIT : K_FOX;
				default: cur.kind = kind_t'($urandom_range(0, 3));
			endcase
			cur.age = 3'($urandom_range(0, 7));
			send_cell(cur);
		end
	endtask

	// Stop offering cells and let every predicted update and the pipeline drain.
	task automatic wait_idle();
		in_valid   <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (open_updates != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Program a grid at a frame boundary and stream whole frames of random cells.
	task automatic run_frames(input logic [6:0] w, input logic [ROW_W-1:0] h,
			input logic [2:0] rabbit_age, input logic [2:0] fox_age,
			input logic [3:0] crowd, input int frames, input int mix);
		int eff_w;
		int eff_h;
		eff_w = (w < 3) ? 3 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
		eff_h = (h < 3) ? 3 : h;
		wait_idle();
		program_grid(w, h, rabbit_age, fox_age, crowd);
		send_random(eff_w * eff_h * frames, mix);
	endtask

	initial begin : stimulus
		string      dir_kinds;
		string      dir_ages;
		cell_t      cur;
		int         sel;
		int         rand_start;
		logic [6:0] w;
		logic [11:0] h;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-built 9x3 grid: a fox both crowded and old, a rabbit at the age ceiling,
		// grass losing and keeping its place, ignored ages, grass and fox spawns.
		dir_kinds = "FFFRRGGEFEFRRGGEEFFFRRGEERE";
		dir_ages  = "000000007077250300001000000";
		wait_idle();
		program_grid(7'd9, 12'd3, 3'd7, 3'd2, 4'd1);
		for (int i = 0; i < 27; i++) begin
			case (dir_kinds[i])
				"F":     cur.kind = K_FOX;
				"R":     cur.kind = K_RABBIT;
				"G":     cur.kind = K_GRASS;
				default: cur.kind = K_EMPTY;
			endcase
			cur.age = 3'(dir_ages[i] - "0");
			send_cell(cur);
		end

		// Shrink the width in the middle of a row: the next cell lies past the new
		// width, is dropped and wraps to the next row.
		wait_idle();
		program_grid(7'd20, 12'd6, 3'd0, 3'd7, 4'd15);
		send_random(3 * 20 + 12, 0);
		wait_idle();
		program_grid(7'd8, 12'd6, 3'd0, 3'd7, 4'd15);
		send_random(1 + 2 * 8, 1);

		// Shrink the height below the current row: that row is dropped and the
		// counters wrap to a new frame.
		wait_idle();
		program_grid(7'd5, 12'd10, 3'd7, 3'd0, 4'd0);
		send_random(6 * 5, 2);
		wait_idle();
		program_grid(7'd5, 12'd4, 3'd7, 3'd0, 4'd0);
		send_random(5 + 4 * 5, 3);

		// Random frames; most grids are small, some clamp the width or height.
		rand_start = cells_sent;
		while (cells_sent - rand_start < RANDOM_CELLS) begin
			sel = $urandom_range(0, 9);
			case (sel)
				0: begin
					w = 7'($urandom_range(0, 2));
					h = 12'($urandom_range(0, 2));
				end
				1: begin
					w = 7'($urandom_range(64, 127));
					h = 12'd3;
				end
				2: begin
					w = RST_GRID_WIDTH;
					h = 12'($urandom_range(3, 4));
				end
				default: begin
					w = 7'($urandom_range(3, 12));
					h = 12'($urandom_range(3, 8));
				end
			endcase
			run_frames(w, h, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
				4'($urandom_range(0, 15)), $urandom_range(1, 2), $urandom_range(0, 3));
		end

		// One tall frame on the narrowest width, clamped up to three columns.
		run_frames(7'd2, 12'd40, 3'd6, 3'd6, 4'd9, 1, 0);
		wait_idle();

		$display("Streamed %0d cells through %0d register settings, widths 3 to 64.",
			cells_sent, settings_used);
		$display("Compared %0d cell updates with the predicted next generation.",
			updates_checked);
		if (fail_count == 0 && open_updates == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== predator_prey_automaton_step_top.f =====
hw/rtl/ppa_pkg.sv
hw/rtl/ppa_line_buf.sv
hw/rtl/ppa_evolve.sv
hw/rtl/predator_prey_automaton_step_top.sv
sim/ppa_step_checker.sv
sim/tb_predator_prey_automaton_step_top.sv
